@@ sv/ostt_pkg.sv @@
package ostt_pkg;

  // Width of a stored count: twice a 16-bit offset.
  localparam int CountW = 17;

  // Request operation codes.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  // Response kinds.
  localparam logic [2:0] KIND_SET    = 3'd0;
  localparam logic [2:0] KIND_FULL   = 3'd1;
  localparam logic [2:0] KIND_CANCEL = 3'd2;
  localparam logic [2:0] KIND_FIRED  = 3'd3;
  localparam logic [2:0] KIND_IDLE   = 3'd4;

  // Request transaction.
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] timer_id;
    logic [15:0] offset;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fired_id;
    logic        last;
  } rsp_t;

  // Operation that every cell of the chain performs.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_MATCH,
    OP_BUBBLE,
    OP_SHIFT,
    OP_INSERT,
    OP_DEC
  } cell_op_t;

  // Command broadcast to the chain.
  typedef struct packed {
    cell_op_t            op;
    logic [CountW-1:0]   key_count;
  } cell_cmd_t;

endpackage

@@ sv/one_shot_timer_table.sv @@
// Channel  | Direction | Handshake               | Payload
// req      | in        | req_valid / req_stall   | ostt_pkg::req_t
// rsp      | out       | rsp_valid / rsp_stall   | ostt_pkg::rsp_t
//
// One request is worked at a time; req_stall is low only while the sequencer idles.
// Set and cancel pass through the match and bubble states, bubbling while the freed
// slot travels through the chain, then the place state. A tick pops each expired timer,
// then decrements the rest. Timers live in a chain of SLOTS cells kept in count order.
// Reset empties the table within the reset cycle; no clearing pass is needed.
// While rsp_stall holds a full output register, the sequencer waits at its next result.
module one_shot_timer_table #(
  parameter int SLOTS   = 16,
  parameter int ID_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ostt_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ostt_pkg::rsp_t  rsp
);

  localparam int IdW = (ID_BITS < 16) ? ID_BITS : 16;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MATCH  = 6'b000010,
    ST_BUBBLE = 6'b000100,
    ST_PLACE  = 6'b001000,
    ST_TICK   = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t                      state, state_next;
  logic [1:0]                  op_func;
  logic [IdW-1:0]              op_id;
  logic [ostt_pkg::CountW-1:0] op_count;
  logic                        fired_any, fired_any_next;
  ostt_pkg::cell_cmd_t         cmd;
  logic                        rsp_load;
  ostt_pkg::rsp_t              rsp_next;
  logic                        rsp_free;

  logic [SLOTS-1:0]            c_valid;
  logic [SLOTS-1:0]            c_hole;
  logic [SLOTS-1:0]            c_cmp;
  logic [SLOTS-1:0]            c_fire;
  logic [IdW-1:0]              c_id    [SLOTS];
  logic [ostt_pkg::CountW-1:0] c_count [SLOTS];

  // The chain of timer cells; the ends see an empty neighbor.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                        l_valid, l_cmp, l_hole, r_valid;
    logic [IdW-1:0]              l_id, r_id;
    logic [ostt_pkg::CountW-1:0] l_count, r_count;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_count = '0;
      assign l_cmp   = 1'b0;
      assign l_hole  = 1'b0;
    end else begin : g_inner_l
      assign l_valid = c_valid[i-1];
      assign l_id    = c_id[i-1];
      assign l_count = c_count[i-1];
      assign l_cmp   = c_cmp[i-1];
      assign l_hole  = c_hole[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_id    = '0;
      assign r_count = '0;
    end else begin : g_inner_r
      assign r_valid = c_valid[i+1];
      assign r_id    = c_id[i+1];
      assign r_count = c_count[i+1];
    end

    ostt_cell #(
      .ID_W(IdW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .key_id     (op_id),
      .left_valid (l_valid),
      .left_id    (l_id),
      .left_count (l_count),
      .left_cmp   (l_cmp),
      .left_hole  (l_hole),
      .right_valid(r_valid),
      .right_id   (r_id),
      .right_count(r_count),
      .valid      (c_valid[i]),
      .id         (c_id[i]),
      .count      (c_count[i]),
      .hole       (c_hole[i]),
      .cmp        (c_cmp[i]),
      .fire       (c_fire[i])
    );
  end

  assign req_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Sequencer: picks the chain operation and the result for this cycle.
  always_comb begin
    state_next     = state;
    fired_any_next = fired_any;
    cmd.op         = ostt_pkg::OP_HOLD;
    cmd.key_count  = op_count;
    rsp_load       = 1'b0;
    rsp_next       = '0;
    case (state)
      ST_IDLE: begin
        fired_any_next = 1'b0;
        if (req_valid) begin
          case (req.func)
            ostt_pkg::FUNC_TICK: begin
              state_next = ST_TICK;
            end
            ostt_pkg::FUNC_SET, ostt_pkg::FUNC_CANCEL: begin
              state_next = ST_MATCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MATCH: begin
        cmd.op     = ostt_pkg::OP_MATCH;
        state_next = ST_BUBBLE;
      end
      ST_BUBBLE: begin
        if (|c_hole) begin
          cmd.op = ostt_pkg::OP_BUBBLE;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (rsp_free) begin
          rsp_load          = 1'b1;
          rsp_next.fired_id = 16'(op_id);
          rsp_next.last     = 1'b1;
          if (op_func == ostt_pkg::FUNC_SET) begin
            if (c_valid[SLOTS-1]) begin
              rsp_next.kind = ostt_pkg::KIND_FULL;
            end else begin
              rsp_next.kind = ostt_pkg::KIND_SET;
              cmd.op        = ostt_pkg::OP_INSERT;
            end
          end else begin
            rsp_next.kind = ostt_pkg::KIND_CANCEL;
          end
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        // Expired timers form the head of the chain; pop them one by one.
        if (c_fire[0]) begin
          if (rsp_free) begin
            rsp_load          = 1'b1;
            rsp_next.kind     = ostt_pkg::KIND_FIRED;
            rsp_next.fired_id = 16'(c_id[0]);
            rsp_next.last     = !c_fire[1];
            cmd.op            = ostt_pkg::OP_SHIFT;
            fired_any_next    = 1'b1;
          end
        end else if (fired_any) begin
          cmd.op     = ostt_pkg::OP_DEC;
          state_next = ST_IDLE;
        end else if (rsp_free) begin
          rsp_load      = 1'b1;
          rsp_next.kind = ostt_pkg::KIND_IDLE;
          rsp_next.last = 1'b1;
          cmd.op        = ostt_pkg::OP_DEC;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fired_any <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fired_any <= fired_any_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture and output register.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      op_func  <= req.func;
      op_id    <= req.timer_id[IdW-1:0];
      op_count <= {req.offset, 1'b0};
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ sv/ostt_cell.sv @@
module ostt_cell #(
  parameter int ID_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ostt_pkg::cell_cmd_t       cmd,
  input  logic [ID_W-1:0]           key_id,
  input  logic                      left_valid,
  input  logic [ID_W-1:0]           left_id,
  input  logic [ostt_pkg::CountW-1:0] left_count,
  input  logic                      left_cmp,
  input  logic                      left_hole,
  input  logic                      right_valid,
  input  logic [ID_W-1:0]           right_id,
  input  logic [ostt_pkg::CountW-1:0] right_count,
  output logic                      valid,
  output logic [ID_W-1:0]           id,
  output logic [ostt_pkg::CountW-1:0] count,
  output logic                      hole,
  output logic                      cmp,
  output logic                      fire
);

  // An empty cell sorts after every timer; a timer with count of one or less
  // expires on the coming tick.
  always_comb begin
    cmp  = !valid || (count > cmd.key_count);
    fire = valid && (count <= ostt_pkg::CountW'(1));
  end

  // One step of the chain operation selected by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hole  <= 1'b0;
    end else begin
      case (cmd.op)
        ostt_pkg::OP_MATCH: begin
          hole <= valid && (id == key_id);
        end
        ostt_pkg::OP_BUBBLE: begin
          // A hole pulls its right neighbor in; the neighbor becomes the hole.
          if (hole) begin
            valid <= right_valid;
            id    <= right_id;
            count <= right_count;
            hole  <= 1'b0;
          end else begin
            hole <= left_hole && valid;
          end
        end
        ostt_pkg::OP_SHIFT: begin
          valid <= right_valid;
          id    <= right_id;
          count <= right_count;
        end
        ostt_pkg::OP_INSERT: begin
          // Cells past the insertion point move right by one.
          if (cmp) begin
            if (left_cmp) begin
              valid <= left_valid;
              id    <= left_id;
              count <= left_count;
            end else begin
              valid <= 1'b1;
              id    <= key_id;
              count <= cmd.key_count;
            end
          end
        end
        ostt_pkg::OP_DEC: begin
          if (valid) begin
            count <= count - ostt_pkg::CountW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
